[src/tbs_pkg.sv]
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and constants of the token bucket shaper: request and result
// payloads, queue entry layout and event status codes.
// ----------------------------------------------------------------------------
package tbs_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 64;
	localparam int unsigned TOKEN_W         = 16;
	localparam int unsigned SEQ_W           = 32;
	localparam int unsigned COUNT_W         = 7;

	localparam logic [TOKEN_W-1:0] DEPTH_RESET = TOKEN_W'(10);

	typedef enum logic [2:0] {
		ST_TOKEN_ADDED   = 3'd0,
		ST_TOKEN_DROPPED = 3'd1,
		ST_QUEUED        = 3'd2,
		ST_TOO_BIG       = 3'd3,
		ST_QUEUE_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic               req_type;
		logic [TOKEN_W-1:0] packet_tokens;
	} req_t;

	typedef struct packed {
		status_t            event_status;
		logic [SEQ_W-1:0]   arrival_number;
		logic               released;
		logic [SEQ_W-1:0]   released_number;
		logic [TOKEN_W-1:0] released_tokens;
		logic [TOKEN_W-1:0] bucket_level;
		logic [COUNT_W-1:0] queue_count;
	} res_t;

	typedef struct packed {
		logic [SEQ_W-1:0]   number;
		logic [TOKEN_W-1:0] tokens;
	} entry_t;

endpackage

[src/tbs_queue_mem.sv]
// ----------------------------------------------------------------------------
// tbs_queue_mem
// Wait queue storage: one write port, one read port with registered data.
// A write to the address being read passes its data to the read register.
// ----------------------------------------------------------------------------
module tbs_queue_mem import tbs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [PTR_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic [PTR_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [QUEUE_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/tbs_core.sv]
// ----------------------------------------------------------------------------
// tbs_core
// Bucket level, queue pointers and sequence counter. Evaluates one request per
// cycle if push_ready, on the prefetched head entry; drives the queue memory.
// ----------------------------------------------------------------------------
module tbs_core import tbs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH),
	localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [TOKEN_W-1:0] cfg_wdata,
	input  logic               in_valid,
	input  req_t               in_req,
	input  logic               push_ready,
	output logic               push_valid,
	output res_t               push_res,
	output logic               wr_en,
	output logic [PTR_W-1:0]   wr_addr,
	output entry_t             wr_data,
	output logic [PTR_W-1:0]   rd_addr,
	input  entry_t             rd_data
);

	logic [TOKEN_W-1:0] depth_q;
	logic [TOKEN_W-1:0] level_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [FILL_W-1:0]  fill_q;
	logic [SEQ_W-1:0]   seq_q;

	logic               accept;
	logic [SEQ_W-1:0]   seq_n;
	logic               tick_add;
	logic               too_big;
	logic               full;
	status_t            status;
	logic [SEQ_W-1:0]   arrival;
	logic               try_rel;
	logic               enq;
	logic [TOKEN_W-1:0] lvl_mid;
	logic [FILL_W-1:0]  fill_mid;
	entry_t             head_ent;
	logic               rel;
	logic [TOKEN_W-1:0] lvl_n;
	logic [FILL_W-1:0]  fill_n;
	logic [PTR_W-1:0]   head_inc;
	logic [PTR_W-1:0]   tail_inc;
	logic [PTR_W-1:0]   head_n;

	assign accept   = in_valid && push_ready;
	assign seq_n    = seq_q + SEQ_W'(1);
	assign tick_add = level_q < depth_q;
	assign too_big  = in_req.packet_tokens > depth_q;
	assign full     = fill_q == FILL_W'(QUEUE_DEPTH);

	always_comb begin
		status  = ST_TOKEN_DROPPED;
		arrival = '0;
		try_rel = 1'b0;
		enq     = 1'b0;
		lvl_mid = level_q;
		if (!in_req.req_type) begin
			try_rel = 1'b1;
			if (tick_add) begin
				lvl_mid = level_q + TOKEN_W'(1);
				status  = ST_TOKEN_ADDED;
			end
		end else begin
			arrival = seq_n;
			priority if (too_big) begin
				status = ST_TOO_BIG;
			end else if (full) begin
				status = ST_QUEUE_FULL;
			end else begin
				status  = ST_QUEUED;
				enq     = 1'b1;
				try_rel = 1'b1;
			end
		end
	end

	assign fill_mid = enq ? fill_q + FILL_W'(1) : fill_q;

	// empty queue: the arriving packet is the head
	always_comb begin
		if (fill_q == '0) begin
			head_ent.number = seq_n;
			head_ent.tokens = in_req.packet_tokens;
		end else begin
			head_ent = rd_data;
		end
	end

	assign rel    = try_rel && (fill_mid != '0) && (head_ent.tokens <= lvl_mid);
	assign lvl_n  = rel ? lvl_mid - head_ent.tokens : lvl_mid;
	assign fill_n = rel ? fill_mid - FILL_W'(1) : fill_mid;

	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
	assign head_n   = (accept && rel) ? head_inc : head_q;

	assign rd_addr        = head_n;
	assign wr_en          = accept && enq;
	assign wr_addr        = tail_q;
	assign wr_data.number = seq_n;
	assign wr_data.tokens = in_req.packet_tokens;

	assign push_valid               = accept;
	assign push_res.event_status    = status;
	assign push_res.arrival_number  = arrival;
	assign push_res.released        = rel;
	assign push_res.released_number = rel ? head_ent.number : '0;
	assign push_res.released_tokens = rel ? head_ent.tokens : '0;
	assign push_res.bucket_level    = lvl_n;
	assign push_res.queue_count     = COUNT_W'(fill_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			depth_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			seq_q   <= '0;
		end else if (accept) begin
			level_q <= lvl_n;
			head_q  <= head_n;
			fill_q  <= fill_n;
			if (enq) begin
				tail_q <= tail_inc;
			end
			if (in_req.req_type) begin
				seq_q <= seq_n;
			end
		end
	end

endmodule

[src/tbs_out_buf.sv]
// ----------------------------------------------------------------------------
// tbs_out_buf
// Two-entry result buffer: output register plus skid register, so the core
// can take one more request while a result waits downstream.
// ----------------------------------------------------------------------------
module tbs_out_buf import tbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  res_t push_res,
	output logic push_ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	res_t main_q;
	res_t skid_q;
	logic main_v_q;
	logic skid_v_q;

	assign push_ready = !skid_v_q;
	assign out_valid  = main_v_q;
	assign out_res    = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_ready) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push_valid;
			end
		end else if (push_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) begin
			main_q <= skid_v_q ? skid_q : push_res;
		end
		if (push_valid && push_ready && main_v_q && !out_ready) begin
			skid_q <= push_res;
		end
	end

endmodule

[src/token_bucket_shaper_top.sv]
// ----------------------------------------------------------------------------
// token_bucket_shaper_top
// Token bucket shaper with a wait queue of packets held in on-chip memory.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------
//   in      | input     | in_valid / in_ready     | in_req
//   out     | output    | out_valid / out_ready   | out_res
//   cfg     | input     | cfg_we (no wait)        | cfg_wdata
//
// One request per cycle while in_ready is high; each result is registered in the
// output register, or in the skid register while the output stalls. The rate
// rests on the head read-modify-write: next head read and pointer update share an edge.
// Reset clears bucket, pointers and counter and loads the default depth; no memory sweep.
// A stalled output holds one more result in a skid register, then in_ready drops.
// ----------------------------------------------------------------------------
module token_bucket_shaper_top import tbs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  req_t               in_req,
	output logic               out_valid,
	input  logic               out_ready,
	output res_t               out_res,
	input  logic               cfg_we,
	input  logic [TOKEN_W-1:0] cfg_wdata
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	logic             push_valid;
	logic             push_ready;
	res_t             push_res;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	entry_t           wr_data;
	logic [PTR_W-1:0] rd_addr;
	entry_t           rd_data;

	assign in_ready = push_ready;

	tbs_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_req     (in_req),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_res   (push_res),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	tbs_queue_mem #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tbs_out_buf u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_res   (push_res),
		.push_ready (push_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (out_res)
	);

endmodule

[src/tbs_checker.sv]
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks of the token bucket shaper, bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker import tbs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input req_t               in_req,
	input logic               out_valid,
	input logic               out_ready,
	input res_t               out_res
);

	logic dropped;
	assign dropped = (out_res.event_status == ST_TOO_BIG) ||
		(out_res.event_status == ST_QUEUE_FULL);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_res))
		else $error("result changed while stalled");

	a_drop_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> !out_res.released)
		else $error("dropped request released a packet");

	a_tick_no_arrival: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_res.event_status == ST_TOKEN_ADDED) ||
		(out_res.event_status == ST_TOKEN_DROPPED)) |-> out_res.arrival_number == '0)
		else $error("token tick carries an arrival number");

	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_res.released |->
		out_res.released_number == '0 && out_res.released_tokens == '0)
		else $error("release fields set without a release");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_req))
		else $error("request changed while waiting");

endmodule

bind token_bucket_shaper_top tbs_checker u_chk (.*);
